### design/hcs_pkg.sv
package hcs_pkg;

    localparam int unsigned PixW = 8;
    localparam int unsigned QueueDepth = 4;
    localparam logic [PixW-1:0] FullScale = 8'd255;

    typedef enum logic {
        OP_LOAD = 1'b0,
        OP_MAP  = 1'b1
    } op_t;

    typedef struct packed {
        logic            is_map;
        logic            first;
        logic            selected;
        logic [PixW-1:0] blue;
        logic [PixW-1:0] green;
        logic [PixW-1:0] red;
        logic [PixW-1:0] alpha;
    } cmd_t;

    typedef struct packed {
        logic [PixW-1:0] blue;
        logic [PixW-1:0] green;
        logic [PixW-1:0] red;
        logic [PixW-1:0] alpha;
    } pix_t;

endpackage

### design/hcs_queue.sv
module hcs_queue
    import hcs_pkg::*;
#(
    parameter int unsigned DEPTH = QueueDepth,
    parameter int unsigned WIDTH = $bits(cmd_t)
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             rd,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);
    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0]    wp_reg, rp_reg;
    logic [AW:0]      cnt_reg;
    logic             do_wr, do_rd;

    assign full  = (cnt_reg == AW'(0) + (AW+1)'(DEPTH));
    assign empty = (cnt_reg == '0);
    assign do_wr = wr && !full;
    assign do_rd = rd && !empty;
    assign rdata = mem_reg[rp_reg];

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wp_reg] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wp_reg <= (wp_reg == AW'(DEPTH-1)) ? '0 : wp_reg + 1'b1;
            end
            if (do_rd)
            begin
                rp_reg <= (rp_reg == AW'(DEPTH-1)) ? '0 : rp_reg + 1'b1;
            end
            cnt_reg <= cnt_reg + (AW+1)'(do_wr) - (AW+1)'(do_rd);
        end
    end
endmodule

### design/hcs_back.sv
module hcs_back
    import hcs_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic cmd_valid,
    input  cmd_t cmd,
    output logic cmd_take,
    output logic res_valid,
    output pix_t res,
    input  logic res_take
);
    typedef enum logic [1:0] {M_PASS, M_ZERO, M_FULL, M_DIV} mode_t;

    // per channel: 0 blue, 1 green, 2 red
    logic [PixW-1:0] lo_reg [3];
    logic [PixW-1:0] hi_reg [3];
    logic [PixW-1:0] v_in [3];
    logic [PixW-1:0] num [3];
    logic [PixW-1:0] span [3];
    logic [PixW-1:0] pass [3];
    logic [PixW-1:0] q [3];
    mode_t           mode [3];

    // divider stage state
    typedef enum logic [1:0] {S_IDLE, S_DIV, S_OUT} st_t;
    st_t st_reg;
    logic [3:0]        step_reg;
    logic [15:0]       rem_reg [3];
    logic [PixW-1:0]   den_reg [3];
    logic [PixW-1:0]   quo_reg [3];
    mode_t             mode_reg [3];
    logic [PixW-1:0]   val_reg [3];
    logic [PixW-1:0]   alpha_reg;
    pix_t              res_reg;
    logic              res_valid_reg;

    assign v_in[0] = cmd.blue;
    assign v_in[1] = cmd.green;
    assign v_in[2] = cmd.red;

    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            num[c]  = v_in[c] - lo_reg[c];
            span[c] = hi_reg[c] - lo_reg[c];
            pass[c] = v_in[c];
            if (!cmd.selected || hi_reg[c] <= lo_reg[c]) mode[c] = M_PASS;
            else if (v_in[c] <= lo_reg[c])               mode[c] = M_ZERO;
            else if (v_in[c] >= hi_reg[c])               mode[c] = M_FULL;
            else                                         mode[c] = M_DIV;
            case (mode_reg[c])
                M_PASS:  q[c] = val_reg[c];
                M_ZERO:  q[c] = '0;
                M_FULL:  q[c] = FullScale;
                default: q[c] = quo_reg[c];
            endcase
        end
    end

    // loads retire at once; maps need an empty output slot
    assign cmd_take = cmd_valid && (st_reg == S_IDLE) &&
                      (!cmd.is_map || !res_valid_reg || res_take);
    assign res_valid = res_valid_reg;
    assign res = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg        <= S_IDLE;
            step_reg      <= '0;
            res_valid_reg <= 1'b0;
            for (int c = 0; c < 3; c++)
            begin
                lo_reg[c] <= 8'd255;
                hi_reg[c] <= 8'd0;
            end
        end
        else
        begin
            if (res_take && res_valid_reg) res_valid_reg <= 1'b0;
            case (st_reg)
                S_IDLE:
                begin
                    if (cmd_take && !cmd.is_map)
                    begin
                        for (int c = 0; c < 3; c++)
                        begin
                            if (cmd.first || v_in[c] < lo_reg[c]) lo_reg[c] <= v_in[c];
                            if (cmd.first || v_in[c] > hi_reg[c]) hi_reg[c] <= v_in[c];
                        end
                    end
                    else if (cmd_take)
                    begin
                        for (int c = 0; c < 3; c++)
                        begin
                            rem_reg[c]  <= {num[c], 8'd0} - {8'd0, num[c]};
                            den_reg[c]  <= span[c];
                            quo_reg[c]  <= '0;
                            mode_reg[c] <= mode[c];
                            val_reg[c]  <= pass[c];
                        end
                        alpha_reg <= cmd.alpha;
                        step_reg  <= '0;
                        st_reg    <= S_DIV;
                    end
                end
                S_DIV:
                begin
                    // restoring division, one quotient bit per cycle
                    for (int c = 0; c < 3; c++)
                    begin
                        if (rem_reg[c] >= ({8'd0, den_reg[c]} << (3'd7 - step_reg[2:0])))
                        begin
                            rem_reg[c] <= rem_reg[c] -
                                ({8'd0, den_reg[c]} << (3'd7 - step_reg[2:0]));
                            quo_reg[c][3'd7 - step_reg[2:0]] <= 1'b1;
                        end
                    end
                    step_reg <= step_reg + 1'b1;
                    if (step_reg == 4'd7) st_reg <= S_OUT;
                end
                S_OUT:
                begin
                    res_reg.blue  <= q[0];
                    res_reg.green <= q[1];
                    res_reg.red   <= q[2];
                    res_reg.alpha <= alpha_reg;
                    res_valid_reg <= 1'b1;
                    st_reg        <= S_IDLE;
                end
                default: st_reg <= S_IDLE;
            endcase
        end
    end
endmodule

### design/histogram_contrast_stretch_unit.sv
// Min/max contrast stretch. Load items (operation=0) update per-channel
// bounds and give no result; first=1 restarts the bounds.
// Map items (operation=1) give one result each: selected channels become
// floor((v-min)*255/(max-min)), others pass unchanged, as do flat or
// unloaded channels. A four-entry item queue fronts the back end, so push
// sees full only when it fills. In the back end a map item passes entry,
// the per-channel bit-serial dividers (8 quotient bits, one per cycle)
// and an output step; the back end takes no new item until that is done.
module histogram_contrast_stretch_unit
    import hcs_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = QueueDepth
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    output logic            full,
    input  logic            operation,
    input  logic            first,
    input  logic            selected,
    input  logic [PixW-1:0] blue_in,
    input  logic [PixW-1:0] green_in,
    input  logic [PixW-1:0] red_in,
    input  logic [PixW-1:0] alpha_in,
    output logic            empty,
    input  logic            pop,
    output logic [PixW-1:0] blue_out,
    output logic [PixW-1:0] green_out,
    output logic [PixW-1:0] red_out,
    output logic [PixW-1:0] alpha_out
);
    cmd_t in_cmd, q_cmd;
    logic q_empty, q_take, res_valid;
    pix_t res;

    // front: classify the item
    always_comb
    begin
        in_cmd.is_map   = (op_t'(operation) == OP_MAP);
        in_cmd.first    = first;
        in_cmd.selected = selected;
        in_cmd.blue     = blue_in;
        in_cmd.green    = green_in;
        in_cmd.red      = red_in;
        in_cmd.alpha    = alpha_in;
    end

    hcs_queue #(.DEPTH(QUEUE_DEPTH), .WIDTH($bits(cmd_t))) u_queue (
        .clk(clk), .rst_n(rst_n),
        .wr(push), .wdata(in_cmd), .full(full),
        .rd(q_take), .rdata(q_cmd), .empty(q_empty)
    );

    hcs_back u_back (
        .clk(clk), .rst_n(rst_n),
        .cmd_valid(!q_empty), .cmd(q_cmd), .cmd_take(q_take),
        .res_valid(res_valid), .res(res), .res_take(pop)
    );

    assign empty     = !res_valid;
    assign blue_out  = res.blue;
    assign green_out = res.green;
    assign red_out   = res.red;
    assign alpha_out = res.alpha;
endmodule

### design/hcs_checker.sv
module hcs_checker
    import hcs_pkg::*;
(
    input logic            clk,
    input logic            rst_n,
    input logic            push,
    input logic            full,
    input logic            empty,
    input logic            pop,
    input logic [PixW-1:0] alpha_out
);
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(alpha_out)))
        else $error("result changed while waiting");

    a_full_needs_push: assert property (@(posedge clk) disable iff (!rst_n)
        (!full && !push) |=> !full)
        else $error("full rose with no item pushed");

    a_known: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> !$isunknown(alpha_out))
        else $error("unknown result on output");

    a_reset: assert property (@(posedge clk)
        !rst_n |-> (empty && !full))
        else $error("bad reset flags");
endmodule

bind histogram_contrast_stretch_unit hcs_checker u_hcs_checker (
    .clk(clk), .rst_n(rst_n), .push(push), .full(full),
    .empty(empty), .pop(pop), .alpha_out(alpha_out)
);
